@@ hw/rtl/pfec_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helpers for the per-flow ECN counter.
package pfec_pkg;

	localparam int FLOW_ENTRIES_DEF = 64;
	localparam int NUM_CTRS         = 8;
	localparam int CTR_W            = 32;
	localparam int FLOW_LIMIT_W     = 7;
	localparam int CFG_ADDR_W       = 3;
	localparam int CFG_DATA_W       = 32;

	localparam logic [FLOW_LIMIT_W-1:0] FLOW_LIMIT_RST = 7'd64;
	localparam logic [0:0]              REG_FLOW_LIMIT = 1'b0;

	localparam logic [15:0] ETH_IPV4  = 16'h0800;
	localparam logic [15:0] ETH_IPV6  = 16'h86DD;
	localparam logic [7:0]  PROTO_TCP = 8'd6;
	localparam logic [1:0]  ECN_MASK  = 2'b11;

	localparam logic [7:0] FLAG_CWR = 8'h80;
	localparam logic [7:0] FLAG_ECE = 8'h40;
	localparam logic [7:0] FLAG_ACK = 8'h10;
	localparam logic [7:0] FLAG_SYN = 8'h02;
	localparam logic [7:0] SYNACK_ECE_CWR = FLAG_SYN | FLAG_ACK | FLAG_ECE | FLAG_CWR;

	localparam int CTR_NOT_ECT    = 0;
	localparam int CTR_ECT1       = 1;
	localparam int CTR_ECT0       = 2;
	localparam int CTR_CE         = 3;
	localparam int CTR_SYNACK_EC  = 4;
	localparam int CTR_ECE_CWR    = 5;
	localparam int CTR_CWR_ONLY   = 6;
	localparam int CTR_ECE_ONLY   = 7;

	typedef enum logic [1:0] {
		STAT_IGNORED = 2'd0,
		STAT_HIT     = 2'd1,
		STAT_NEW     = 2'd2,
		STAT_FULL    = 2'd3
	} pfec_status_t;

	typedef logic [NUM_CTRS-1:0][CTR_W-1:0] pfec_ctrs_t;

	typedef struct packed {
		pfec_status_t status;
		logic [1:0]   ecn;
		pfec_ctrs_t   ctrs;
	} pfec_result_t;

	typedef struct packed {
		logic [FLOW_LIMIT_W-1:0] flow_limit;
	} pfec_cfg_t;

	function automatic logic [NUM_CTRS-1:0] incr_mask(
		input logic [7:0] class_b,
		input logic [7:0] proto,
		input logic [7:0] flags
	);
		logic [NUM_CTRS-1:0] m;
		logic [7:0]          ec;
		m  = '0;
		ec = flags & (FLAG_ECE | FLAG_CWR);
		m[class_b[1:0] & ECN_MASK] = 1'b1;
		if (proto == PROTO_TCP) begin
			m[CTR_SYNACK_EC] = (flags & SYNACK_ECE_CWR) == SYNACK_ECE_CWR;
			m[CTR_ECE_CWR]   = ec == (FLAG_ECE | FLAG_CWR);
			m[CTR_CWR_ONLY]  = ec == FLAG_CWR;
			m[CTR_ECE_ONLY]  = ec == FLAG_ECE;
		end
		return m;
	endfunction

endpackage

@@ hw/rtl/per_flow_ecn_counter_top.sv @@
`timescale 1ns / 1ps
// Per-flow ECN codepoint counter, top level.
//
// Input channel (in_valid/in_ready): one packet header summary per word. The
// flow table lives in two RAMs (keys, and eight 32-bit counters per entry),
// filled in order from entry 0; a fill count stands in for valid bits.
// Lookup scans the key RAM one entry per cycle, the counter RAM being read
// at the same address so a hit updates and writes back in the compare cycle.
// The key scan ends at a hit; a miss (new entry or table full) scans every
// used entry, and an ignored packet or an empty table skips it. A result
// reaches out_valid as the engine returns to idle.
// Output channel (out_valid/out_ready): one result word per input word,
// held in an output register; the next input word is taken while a result
// still waits there. If the receiver stalls longer, the engine holds its
// finished word and in_ready stays low.
// Reset clears the fill count (table empty) and sets flow_limit to 64; no
// clearing pass is needed. flow_limit is written over APB at byte address 0;
// the user must write it only while the block is idle; it is not enforced.
module per_flow_ecn_counter_top #(
	parameter int FLOW_ENTRIES = pfec_pkg::FLOW_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pfec_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [pfec_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [pfec_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [63:0]                     flow_key,
	input  logic [15:0]                     ether_type,
	input  logic                            header_ok,
	input  logic [7:0]                      class_byte,
	input  logic [7:0]                      next_protocol,
	input  logic [7:0]                      tcp_flags,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      status,
	output logic [1:0]                      ecn_class,
	output logic [31:0]                     count_not_ect,
	output logic [31:0]                     count_ect1,
	output logic [31:0]                     count_ect0,
	output logic [31:0]                     count_ce,
	output logic [31:0]                     count_synack_ece_cwr,
	output logic [31:0]                     count_ece_cwr,
	output logic [31:0]                     count_cwr_only,
	output logic [31:0]                     count_ece_only
);

	pfec_pkg::pfec_cfg_t    cfg;
	pfec_pkg::pfec_result_t res;
	pfec_pkg::pfec_result_t out_q;
	logic                   res_valid;
	logic                   res_ready;
	logic                   out_valid_q;

	pfec_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	pfec_engine #(
		.FLOW_ENTRIES(FLOW_ENTRIES)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.flow_key     (flow_key),
		.ether_type   (ether_type),
		.header_ok    (header_ok),
		.class_byte   (class_byte),
		.next_protocol(next_protocol),
		.tcp_flags    (tcp_flags),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid            = out_valid_q;
	assign status               = out_q.status;
	assign ecn_class            = out_q.ecn;
	assign count_not_ect        = out_q.ctrs[pfec_pkg::CTR_NOT_ECT];
	assign count_ect1           = out_q.ctrs[pfec_pkg::CTR_ECT1];
	assign count_ect0           = out_q.ctrs[pfec_pkg::CTR_ECT0];
	assign count_ce             = out_q.ctrs[pfec_pkg::CTR_CE];
	assign count_synack_ece_cwr = out_q.ctrs[pfec_pkg::CTR_SYNACK_EC];
	assign count_ece_cwr        = out_q.ctrs[pfec_pkg::CTR_ECE_CWR];
	assign count_cwr_only       = out_q.ctrs[pfec_pkg::CTR_CWR_ONLY];
	assign count_ece_only       = out_q.ctrs[pfec_pkg::CTR_ECE_ONLY];

endmodule

@@ hw/rtl/pfec_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module pfec_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/pfec_cfg.sv @@
`timescale 1ns / 1ps
// APB configuration register block (flow_limit).
module pfec_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pfec_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [pfec_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [pfec_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                 pready,
	output pfec_pkg::pfec_cfg_t                  cfg
);

	logic [pfec_pkg::FLOW_LIMIT_W-1:0] flow_limit_q;
	logic                              sel_limit;
	logic                              wr_en;

	assign pready    = 1'b1;
	assign sel_limit = paddr[pfec_pkg::CFG_ADDR_W-1:2] == pfec_pkg::REG_FLOW_LIMIT;
	assign wr_en     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_limit_q <= pfec_pkg::FLOW_LIMIT_RST;
		end else if (wr_en && sel_limit) begin
			flow_limit_q <= pwdata[pfec_pkg::FLOW_LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_limit) begin
			prdata = pfec_pkg::CFG_DATA_W'(flow_limit_q);
		end
	end

	assign cfg.flow_limit = flow_limit_q;

endmodule

@@ hw/rtl/pfec_engine.sv @@
`timescale 1ns / 1ps
// Flow lookup sequencer: key scan, counter read-modify-write and insertion.
module pfec_engine #(
	parameter int FLOW_ENTRIES = pfec_pkg::FLOW_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pfec_pkg::pfec_cfg_t   cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [63:0]           flow_key,
	input  logic [15:0]           ether_type,
	input  logic                  header_ok,
	input  logic [7:0]            class_byte,
	input  logic [7:0]            next_protocol,
	input  logic [7:0]            tcp_flags,
	output logic                  res_valid,
	input  logic                  res_ready,
	output pfec_pkg::pfec_result_t res
);

	localparam int IDX_W  = FLOW_ENTRIES > 1 ? $clog2(FLOW_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(FLOW_ENTRIES + 1);
	localparam int CMP_W  = CNT_W > pfec_pkg::FLOW_LIMIT_W ? CNT_W : pfec_pkg::FLOW_LIMIT_W;
	localparam int CTRS_W = pfec_pkg::NUM_CTRS * pfec_pkg::CTR_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MISS,
		ST_FINISH
	} state_t;

	state_t                          state_q;
	logic [63:0]                     key_q;
	logic [1:0]                      ecn_q;
	logic [pfec_pkg::NUM_CTRS-1:0]   inc_q;
	logic [CNT_W-1:0]                issue_idx_q;
	logic [CNT_W-1:0]                used_q;
	logic                            cmp_vld_s1;
	logic [IDX_W-1:0]                cmp_idx_s1;
	pfec_pkg::pfec_result_t          res_q;

	logic                            ignore;
	logic                            issue;
	logic                            match;
	logic                            full;
	logic [CMP_W-1:0]                lim_ext;
	logic [CMP_W-1:0]                cap;
	logic [63:0]                     key_rdata;
	logic [CTRS_W-1:0]               ctr_rdata;
	pfec_pkg::pfec_ctrs_t            ctr_old;
	pfec_pkg::pfec_ctrs_t            ctr_upd;
	pfec_pkg::pfec_ctrs_t            ctr_init;
	logic                            key_we;
	logic                            ctr_we;
	logic [IDX_W-1:0]                ctr_waddr;
	pfec_pkg::pfec_ctrs_t            ctr_wdata;

	assign ignore = (flow_key == 64'd0) ||
		((ether_type != pfec_pkg::ETH_IPV4) && (ether_type != pfec_pkg::ETH_IPV6)) ||
		!header_ok;

	assign in_ready  = state_q == ST_IDLE;
	assign match     = (state_q == ST_SCAN) && cmp_vld_s1 && (key_rdata == key_q);
	assign issue     = (state_q == ST_SCAN) && (issue_idx_q < used_q) && !match;

	assign lim_ext = CMP_W'(cfg.flow_limit);
	assign cap     = (lim_ext > CMP_W'(FLOW_ENTRIES)) ? CMP_W'(FLOW_ENTRIES) : lim_ext;
	assign full    = CMP_W'(used_q) >= cap;

	assign ctr_old = ctr_rdata;

	always_comb begin
		for (int j = 0; j < pfec_pkg::NUM_CTRS; j++) begin
			ctr_upd[j]  = ctr_old[j] + pfec_pkg::CTR_W'(inc_q[j]);
			ctr_init[j] = pfec_pkg::CTR_W'(inc_q[j]);
		end
	end

	assign key_we    = (state_q == ST_MISS) && !full;
	assign ctr_we    = match || key_we;
	assign ctr_waddr = match ? cmp_idx_s1 : used_q[IDX_W-1:0];
	assign ctr_wdata = match ? ctr_upd : ctr_init;

	pfec_ram #(
		.WIDTH(64),
		.DEPTH(FLOW_ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(used_q[IDX_W-1:0]),
		.wdata(key_q),
		.re   (issue),
		.raddr(issue_idx_q[IDX_W-1:0]),
		.rdata(key_rdata)
	);

	pfec_ram #(
		.WIDTH(CTRS_W),
		.DEPTH(FLOW_ENTRIES)
	) u_ctr_ram (
		.clk  (clk),
		.we   (ctr_we),
		.waddr(ctr_waddr),
		.wdata(ctr_wdata),
		.re   (issue),
		.raddr(issue_idx_q[IDX_W-1:0]),
		.rdata(ctr_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_q       <= '0;
			ecn_q       <= '0;
			inc_q       <= '0;
			issue_idx_q <= '0;
			used_q      <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_idx_s1  <= '0;
			res_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						key_q       <= flow_key;
						ecn_q       <= class_byte[1:0] & pfec_pkg::ECN_MASK;
						inc_q       <= pfec_pkg::incr_mask(class_byte, next_protocol,
							tcp_flags);
						issue_idx_q <= '0;
						cmp_vld_s1  <= 1'b0;
						if (ignore) begin
							res_q.status <= pfec_pkg::STAT_IGNORED;
							res_q.ecn    <= '0;
							res_q.ctrs   <= '0;
							state_q      <= ST_FINISH;
						end else if (used_q == '0) begin
							state_q <= ST_MISS;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= issue;
					cmp_idx_s1 <= issue_idx_q[IDX_W-1:0];
					if (issue) begin
						issue_idx_q <= issue_idx_q + 1'b1;
					end
					if (match) begin
						res_q.status <= pfec_pkg::STAT_HIT;
						res_q.ecn    <= ecn_q;
						res_q.ctrs   <= ctr_upd;
						state_q      <= ST_FINISH;
					end else if (!issue && !cmp_vld_s1) begin
						state_q <= ST_MISS;
					end
				end
				ST_MISS: begin
					res_q.ecn <= ecn_q;
					if (full) begin
						res_q.status <= pfec_pkg::STAT_FULL;
						res_q.ctrs   <= '0;
					end else begin
						res_q.status <= pfec_pkg::STAT_NEW;
						res_q.ctrs   <= ctr_init;
						used_q       <= used_q + 1'b1;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = state_q == ST_FINISH;
	assign res       = res_q;

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		match |-> (CNT_W'(cmp_idx_s1) < used_q))
		else $error("hit on an entry beyond the fill count");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != $past(used_q)) |->
			($past(state_q) == ST_MISS && used_q == $past(used_q) + 1'b1))
		else $error("fill count moved outside an insertion");

	a_cmp_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> $past(state_q == ST_SCAN))
		else $error("compare stage loaded outside the scan");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && !res_ready) |=> (state_q == ST_FINISH && $stable(res_q)))
		else $error("finished word lost while output register busy");

endmodule
